// ----- rtl/core/fcgi_dfr_pkg.sv -----
// fcgi_dfr_pkg: shared types, codes and constants of the fastcgi record deframer
// no dependencies; imported by fcgi_dfr_parse, fcgi_dfr_outq and fastcgi_record_deframer_core
`timescale 1ns / 1ps

package fcgi_dfr_pkg;

  // longest status line, in bytes, including the terminating crlf
  localparam int unsigned LINE_MAX = 1024;
  localparam int unsigned LCNT_W   = $clog2(LINE_MAX + 1);
  localparam logic [LCNT_W-1:0] LINE_LAST = LCNT_W'(LINE_MAX - 1);

  // result queue geometry
  localparam int unsigned QDEPTH = 8;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [15:0] EXP_ID_RST = 16'd1;

  // record types
  localparam logic [7:0] REC_END_REQUEST = 8'd3;
  localparam logic [7:0] REC_STDOUT      = 8'd6;
  localparam logic [7:0] REC_STDERR      = 8'd7;
  localparam logic [15:0] END_BODY_LEN   = 16'd8;

  // characters of the status line
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SP = 8'h20;

  // reply code limits
  localparam logic [6:0] CODE_MIN = 7'd10;
  localparam logic [6:0] CODE_LIM = 7'd70;
  localparam logic [6:0] OK_LO    = 7'd20;
  localparam logic [6:0] OK_HI    = 7'd29;

  typedef enum logic [2:0] {
    KIND_BODY   = 3'd0,
    KIND_META   = 3'd1,
    KIND_STATUS = 3'd2,
    KIND_DONE   = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    CAUSE_NONE        = 3'd0,
    CAUSE_BAD_ID      = 3'd1,
    CAUSE_BAD_TYPE    = 3'd2,
    CAUSE_BAD_END_LEN = 3'd3,
    CAUSE_LINE_LONG   = 3'd4,
    CAUSE_SYNTAX      = 3'd5,
    CAUSE_CODE_RANGE  = 3'd6
  } cause_e;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CONTENT,
    PH_PADDING,
    PH_DONE,
    PH_ERROR
  } rec_phase_e;

  typedef enum logic [2:0] {
    LN_TENS,
    LN_UNITS,
    LN_SPACE,
    LN_META,
    LN_COMPLETE
  } line_phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic [6:0]  status;
    cause_e      error_cause;
    logic        last;
  } result_t;

  // results produced by one byte, in order
  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } push_t;

  function automatic result_t mk_res(kind_e kind, logic [7:0] b, logic [6:0] status,
                                     cause_e cause);
    result_t r;
    r.kind        = kind;
    r.out_byte    = b;
    r.status      = status;
    r.error_cause = cause;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

// ----- rtl/core/fcgi_dfr_byte_if.sv -----
// fcgi_dfr_byte_if: valid/ready channel carrying one stream byte per transaction
// no dependencies
`timescale 1ns / 1ps

interface fcgi_dfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source(output valid, output in_byte, input ready);
  modport sink(input valid, input in_byte, output ready);
endinterface

// ----- rtl/core/fcgi_dfr_res_if.sv -----
// fcgi_dfr_res_if: valid/ready channel carrying one deframer result per transaction
// no dependencies
`timescale 1ns / 1ps

interface fcgi_dfr_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] out_byte;
  logic [6:0] status;
  logic [2:0] error_cause;
  logic       last;

  modport source(output valid, output kind, output out_byte, output status,
                 output error_cause, output last, input ready);
  modport sink(input valid, input kind, input out_byte, input status,
               input error_cause, input last, output ready);
endinterface

// ----- rtl/core/fcgi_dfr_parse.sv -----
// fcgi_dfr_parse: record and status-line state machine, one byte per cycle
// depends on fcgi_dfr_pkg
`timescale 1ns / 1ps

module fcgi_dfr_parse import fcgi_dfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        vld_i,
  input  logic [7:0]  byte_i,
  input  logic [15:0] exp_id_i,
  output push_t       push_o
);

  rec_phase_e        rec_q, rec_d;
  line_phase_e       line_q, line_d;
  logic [2:0]        hcnt_q, hcnt_d;
  logic [7:0]        typ_q, typ_d, idh_q, idh_d, idl_q, idl_d;
  logic [7:0]        lenh_q, lenh_d, lenl_q, lenl_d, padh_q, padh_d;
  logic [15:0]       cont_q, cont_d;
  logic [7:0]        padl_q, padl_d;
  logic [LCNT_W-1:0] lcnt_q, lcnt_d;
  logic [3:0]        tens_q, tens_d;
  logic [6:0]        code_q, code_d;
  logic              cr_q, cr_d;

  logic        is_digit, finishing, too_long, stream;
  logic [6:0]  code_calc;
  logic [15:0] hdr_len, cont_dec;
  logic [7:0]  pad_dec;
  logic        hdr_end, line_act, body_res;
  logic        err, done_res, status_res, cr_res, byte_res;
  cause_e      cause;

  assign is_digit  = (byte_i[7:4] == 4'h3) && (byte_i[3:0] <= 4'd9);
  assign code_calc = {tens_q, 3'b000} + {2'b00, tens_q, 1'b0} + {3'b000, byte_i[3:0]};
  assign hdr_len   = {lenh_q, lenl_q};
  assign cont_dec  = cont_q - 16'd1;
  assign pad_dec   = padl_q - 8'd1;
  assign finishing = (line_q == LN_META) && cr_q && (byte_i == CH_LF);
  assign too_long  = (lcnt_q >= LINE_LAST) && !finishing;
  assign stream    = (typ_q == REC_STDOUT) || (typ_q == REC_STDERR);
  assign hdr_end   = vld_i && (rec_q == PH_HEADER) && (hcnt_q == 3'd7);
  assign line_act  = vld_i && (rec_q == PH_CONTENT) && (typ_q == REC_STDOUT)
                     && (line_q != LN_COMPLETE);
  assign body_res  = vld_i && (rec_q == PH_CONTENT) && (typ_q == REC_STDOUT)
                     && (line_q == LN_COMPLETE);

  // decisions taken on the current byte
  always_comb begin
    err        = 1'b0;
    cause      = CAUSE_NONE;
    done_res   = 1'b0;
    status_res = 1'b0;
    cr_res     = 1'b0;
    byte_res   = 1'b0;
    if (hdr_end) begin
      priority if ({idh_q, idl_q} != exp_id_i) begin
        err   = 1'b1;
        cause = CAUSE_BAD_ID;
      end else if (typ_q == REC_END_REQUEST) begin
        if (hdr_len != END_BODY_LEN) begin
          err   = 1'b1;
          cause = CAUSE_BAD_END_LEN;
        end else begin
          done_res = 1'b1;
        end
      end else if (!stream) begin
        err   = 1'b1;
        cause = CAUSE_BAD_TYPE;
      end else begin
        // stdout or stderr header, any content or padding follows
      end
    end else if (line_act) begin
      if (too_long) begin
        err   = 1'b1;
        cause = CAUSE_LINE_LONG;
      end else begin
        unique case (line_q)
          LN_TENS: begin
            if (!is_digit) begin
              err   = 1'b1;
              cause = CAUSE_SYNTAX;
            end
          end
          LN_UNITS: begin
            if (!is_digit) begin
              err   = 1'b1;
              cause = CAUSE_SYNTAX;
            end else if (code_calc < CODE_MIN || code_calc >= CODE_LIM) begin
              err   = 1'b1;
              cause = CAUSE_CODE_RANGE;
            end
          end
          LN_SPACE: begin
            if (byte_i != CH_SP) begin
              err   = 1'b1;
              cause = CAUSE_SYNTAX;
            end
          end
          LN_META: begin
            if (finishing) begin
              status_res = 1'b1;
              done_res   = (code_q < OK_LO) || (code_q > OK_HI);
            end else begin
              cr_res   = cr_q;
              byte_res = (byte_i != CH_CR);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // next state
  always_comb begin
    rec_d  = rec_q;
    line_d = line_q;
    hcnt_d = hcnt_q;
    typ_d  = typ_q;
    idh_d  = idh_q;
    idl_d  = idl_q;
    lenh_d = lenh_q;
    lenl_d = lenl_q;
    padh_d = padh_q;
    cont_d = cont_q;
    padl_d = padl_q;
    lcnt_d = lcnt_q;
    tens_d = tens_q;
    code_d = code_q;
    cr_d   = cr_q;
    if (vld_i) begin
      unique case (rec_q)
        PH_HEADER: begin
          unique case (hcnt_q)
            3'd1:    typ_d  = byte_i;
            3'd2:    idh_d  = byte_i;
            3'd3:    idl_d  = byte_i;
            3'd4:    lenh_d = byte_i;
            3'd5:    lenl_d = byte_i;
            3'd6:    padh_d = byte_i;
            default: ;
          endcase
          hcnt_d = hcnt_q + 3'd1;
          if (hdr_end) begin
            priority if (err) begin
              rec_d = PH_ERROR;
            end else if (done_res) begin
              rec_d = PH_DONE;
            end else begin
              cont_d = hdr_len;
              padl_d = padh_q;
              if (hdr_len != 16'd0) begin
                rec_d = PH_CONTENT;
              end else if (padh_q != 8'd0) begin
                rec_d = PH_PADDING;
              end else begin
                rec_d = PH_HEADER;
              end
            end
          end
        end
        PH_CONTENT: begin
          cont_d = cont_dec;
          if (line_act && !err) begin
            lcnt_d = lcnt_q + LCNT_W'(1);
            unique case (line_q)
              LN_TENS: begin
                tens_d = byte_i[3:0];
                line_d = LN_UNITS;
              end
              LN_UNITS: begin
                code_d = code_calc;
                line_d = LN_SPACE;
              end
              LN_SPACE: line_d = LN_META;
              LN_META: begin
                if (finishing) begin
                  cr_d   = 1'b0;
                  line_d = LN_COMPLETE;
                end else begin
                  cr_d = (byte_i == CH_CR);
                end
              end
              default: ;
            endcase
          end
          priority if (err) begin
            rec_d = PH_ERROR;
          end else if (done_res) begin
            rec_d = PH_DONE;
          end else if (cont_dec == 16'd0) begin
            rec_d = (padl_q != 8'd0) ? PH_PADDING : PH_HEADER;
          end else begin
            // record content goes on
          end
        end
        PH_PADDING: begin
          padl_d = pad_dec;
          if (pad_dec == 8'd0) begin
            rec_d = PH_HEADER;
          end
        end
        default: ;
      endcase
    end
  end

  // results of the current byte
  always_comb begin
    push_o.cnt  = 2'd0;
    push_o.res0 = mk_res(KIND_BODY, 8'd0, 7'd0, CAUSE_NONE);
    push_o.res1 = mk_res(KIND_BODY, 8'd0, 7'd0, CAUSE_NONE);
    priority if (err) begin
      push_o.cnt  = 2'd1;
      push_o.res0 = mk_res(KIND_ERROR, 8'd0, 7'd0, cause);
    end else if (status_res) begin
      push_o.res0 = mk_res(KIND_STATUS, 8'd0, code_q, CAUSE_NONE);
      push_o.res1 = mk_res(KIND_DONE, 8'd0, 7'd0, CAUSE_NONE);
      push_o.cnt  = done_res ? 2'd2 : 2'd1;
    end else if (done_res) begin
      push_o.cnt  = 2'd1;
      push_o.res0 = mk_res(KIND_DONE, 8'd0, 7'd0, CAUSE_NONE);
    end else if (cr_res) begin
      push_o.res0 = mk_res(KIND_META, CH_CR, 7'd0, CAUSE_NONE);
      push_o.res1 = mk_res(KIND_META, byte_i, 7'd0, CAUSE_NONE);
      push_o.cnt  = byte_res ? 2'd2 : 2'd1;
    end else if (byte_res) begin
      push_o.cnt  = 2'd1;
      push_o.res0 = mk_res(KIND_META, byte_i, 7'd0, CAUSE_NONE);
    end else if (body_res) begin
      push_o.cnt  = 2'd1;
      push_o.res0 = mk_res(KIND_BODY, byte_i, 7'd0, CAUSE_NONE);
    end else begin
      // no result for this byte
    end
    push_o.res0.last = (push_o.cnt == 2'd1);
    push_o.res1.last = (push_o.cnt == 2'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q  <= PH_HEADER;
      line_q <= LN_TENS;
      hcnt_q <= 3'd0;
      typ_q  <= 8'd0;
      idh_q  <= 8'd0;
      idl_q  <= 8'd0;
      lenh_q <= 8'd0;
      lenl_q <= 8'd0;
      padh_q <= 8'd0;
      cont_q <= 16'd0;
      padl_q <= 8'd0;
      lcnt_q <= '0;
      tens_q <= 4'd0;
      code_q <= 7'd0;
      cr_q   <= 1'b0;
    end else begin
      rec_q  <= rec_d;
      line_q <= line_d;
      hcnt_q <= hcnt_d;
      typ_q  <= typ_d;
      idh_q  <= idh_d;
      idl_q  <= idl_d;
      lenh_q <= lenh_d;
      lenl_q <= lenl_d;
      padh_q <= padh_d;
      cont_q <= cont_d;
      padl_q <= padl_d;
      lcnt_q <= lcnt_d;
      tens_q <= tens_d;
      code_q <= code_d;
      cr_q   <= cr_d;
    end
  end

endmodule

// ----- rtl/core/fcgi_dfr_outq.sv -----
// fcgi_dfr_outq: small result queue taking up to two results per cycle
// depends on fcgi_dfr_pkg
`timescale 1ns / 1ps

module fcgi_dfr_outq import fcgi_dfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  push_t             push_i,
  input  logic              pop_i,
  output result_t           head_o,
  output logic              valid_o,
  output logic [QCNT_W-1:0] free_o
);

  result_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d, wr_nx;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign wr_nx   = wr_q + QPTR_W'(1);
  assign wr_d    = wr_q + QPTR_W'(push_i.cnt);
  assign rd_d    = rd_q + QPTR_W'(pop_i);
  assign cnt_d   = cnt_q + QCNT_W'(push_i.cnt) - QCNT_W'(pop_i);
  assign head_o  = mem_q[rd_q];
  assign valid_o = (cnt_q != '0);
  assign free_o  = QCNT_W'(QDEPTH) - cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_nx] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/fastcgi_record_deframer_core.sv -----
// fastcgi_record_deframer_core: top level of the fastcgi response deframer
// depends on fcgi_dfr_pkg, fcgi_dfr_byte_if, fcgi_dfr_res_if, fcgi_dfr_parse, fcgi_dfr_outq
`timescale 1ns / 1ps

// Takes a FastCGI response stream one byte per transaction and turns it into
// result transactions: body bytes, status-line meta bytes, the two-digit
// reply code, request done, or an error with its cause. An accepted byte is
// held in an input register, then the parser updates its record and
// status-line state and pushes zero, one or two results into an eight-entry
// result queue that drives the output channel. A byte is taken every cycle
// as long as the queue has room for the results of the byte already in flight
// plus two more, so the sustained rate is one byte per cycle while the sink
// keeps up; bytes that produce two results (status plus done, or a held cr
// plus the next meta byte) are bounded by the one-result-per-cycle drain of
// the output channel. After request done or an error every further byte is
// accepted and dropped. expected_id is written through cfg_we_i/cfg_wdata_i;
// the user must write it only while idle; the block itself does not enforce this.

module fastcgi_record_deframer_core import fcgi_dfr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_wdata_i,
  fcgi_dfr_byte_if.sink   in_i,
  fcgi_dfr_res_if.source  out_o
);

  // configured request id
  logic [15:0] exp_id_q;

  // input register
  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        in_acc;

  // queue side
  push_t             push;
  result_t           head;
  logic              q_valid;
  logic [QCNT_W-1:0] q_free;
  logic [QCNT_W-1:0] q_need;

  // room for the byte in flight and for the byte being taken
  assign q_need    = in_vld_q ? QCNT_W'(4) : QCNT_W'(2);
  assign in_i.ready = (q_free >= q_need);
  assign in_acc    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_id_q <= EXP_ID_RST;
      in_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        exp_id_q <= cfg_wdata_i;
      end
      in_vld_q <= in_acc;
    end
  end

  // byte payload needs no reset, it is qualified by in_vld_q
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= in_i.in_byte;
    end
  end

  fcgi_dfr_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (in_vld_q),
    .byte_i   (in_byte_q),
    .exp_id_i (exp_id_q),
    .push_o   (push)
  );

  fcgi_dfr_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (q_valid && out_o.ready),
    .head_o  (head),
    .valid_o (q_valid),
    .free_o  (q_free)
  );

  // output channel straight from the queue head
  assign out_o.valid       = q_valid;
  assign out_o.kind        = head.kind;
  assign out_o.out_byte    = head.out_byte;
  assign out_o.status      = head.status;
  assign out_o.error_cause = head.error_cause;
  assign out_o.last        = head.last;

  // the queue never overflows: the ready rule reserves room ahead of time
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    QCNT_W'(push.cnt) <= q_free)
    else $error("result queue overflow");

  // nothing is pushed without a byte in the input register
  a_push_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> push.cnt == 2'd0)
    else $error("result pushed without an input byte");

  // after done or error the parser stays silent
  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt == 2'd1 && (push.res0.kind == KIND_DONE || push.res0.kind == KIND_ERROR)) ||
    (push.cnt == 2'd2 && push.res1.kind == KIND_DONE)
    |=> push.cnt == 2'd0)
    else $error("result after request end");

  // an error is always the only result of its byte
  a_error_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.cnt == 2'd2 |-> push.res0.kind != KIND_ERROR && push.res1.kind != KIND_ERROR)
    else $error("error result shares a byte with another result");

endmodule
